// File: design/bgcr_pkg.sv
`default_nettype none

package bgcr_pkg;

    // field widths
    localparam int COL_W    = 7;
    localparam int ROW_W    = 6;
    localparam int SAMPLE_W = 16;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    // sample * height and the running multiple of max_value fit in this width
    localparam int PROD_W   = 22;
    localparam int HEIGHT_W = ROW_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_DRAW     = 2'd0,
        OP_INV_COL  = 2'd1,
        OP_CURSOR   = 2'd2,
        OP_INV_ALL  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAPH_LEFT   = 3'd0,
        REG_GRAPH_TOP    = 3'd1,
        REG_GRAPH_BOTTOM = 3'd2,
        REG_MAX_VALUE    = 3'd3,
        REG_MASK_LEFT    = 3'd4,
        REG_MASK_RIGHT   = 3'd5,
        REG_MASK_TOP     = 3'd6,
        REG_MASK_BOTTOM  = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SETUP = 2'd1,
        ST_RUN   = 2'd2
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_is_draw;
        logic go;
        logic row_emit;
        logic out_free;
        logic final_row;
    } status_t;

endpackage

`default_nettype wire

// File: design/bgcr_in_if.sv
`default_nettype none

interface bgcr_in_if;
    import bgcr_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [COL_W-1:0]    column_index;
    logic [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output opcode, output column_index,
                    output sample_value, input ready);
    modport sink   (input valid, input opcode, input column_index,
                    input sample_value, output ready);
endinterface

`default_nettype wire

// File: design/bgcr_out_if.sv
`default_nettype none

interface bgcr_out_if;
    import bgcr_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0] pixel_x;
    logic [ROW_W-1:0] pixel_y;
    logic             pixel_color;
    logic             last_pixel;

    modport source (output valid, output pixel_x, output pixel_y,
                    output pixel_color, output last_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y,
                    input pixel_color, input last_pixel, output ready);
endinterface

`default_nettype wire

// File: design/bgcr_ctrl.sv
`default_nettype none

module bgcr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire bgcr_pkg::status_t status,
    output bgcr_pkg::cmd_t         cmd
);
    import bgcr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.in_is_draw)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = status.go ? ST_RUN : ST_IDLE;
            end
            ST_RUN:
            begin
                if ((!status.row_emit || status.out_free) && status.final_row)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        cmd.load  = 1'b0;
        cmd.setup = 1'b0;
        cmd.step  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            ST_RUN:
            begin
                // skipped rows advance freely, emitted rows wait for a free output slot
                cmd.step = !status.row_emit || status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/bgcr_dp.sv
`default_nettype none

module bgcr_dp #(
    parameter int NUM_COLUMNS  = 128,
    parameter int DISPLAY_ROWS = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [bgcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bgcr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [bgcr_pkg::OP_W-1:0]      in_opcode,
    input  wire logic [bgcr_pkg::COL_W-1:0]     in_column,
    input  wire logic [bgcr_pkg::SAMPLE_W-1:0]  in_sample,
    input  wire bgcr_pkg::cmd_t                 cmd,
    output bgcr_pkg::status_t                   status,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic [bgcr_pkg::COL_W-1:0]          out_x,
    output logic [bgcr_pkg::ROW_W-1:0]          out_y,
    output logic                                out_color,
    output logic                                out_last
);
    import bgcr_pkg::*;

    localparam int IDX_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam logic [COL_W:0]   NCOL    = (COL_W + 1)'(NUM_COLUMNS);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(DISPLAY_ROWS - 1);

    // configuration registers
    logic [COL_W-1:0]    graph_left_reg;
    logic [ROW_W-1:0]    graph_top_reg;
    logic [ROW_W-1:0]    graph_bottom_reg;
    logic [SAMPLE_W-1:0] max_value_reg;
    logic [COL_W-1:0]    mask_left_reg;
    logic [COL_W-1:0]    mask_right_reg;
    logic [ROW_W-1:0]    mask_top_reg;
    logic [ROW_W-1:0]    mask_bottom_reg;

    // per-column clean flags: reset clears them, so every column starts dirty
    logic [NUM_COLUMNS-1:0] clean_reg;
    logic [NUM_COLUMNS-1:0] clean_next;
    logic [COL_W-1:0]       cursor_reg;

    // latched draw item
    logic [COL_W-1:0]    col_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    // column walk state
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   acc_reg;
    logic                mode_pass_reg;
    logic                mode_full_reg;
    logic                fg_reg;
    logic [COL_W-1:0]    x_reg;
    logic                xin_reg;
    logic [ROW_W-1:0]    y_reg;
    logic [ROW_W-1:0]    r_reg;
    logic [ROW_W-1:0]    last_y_reg;

    // output register
    logic                out_valid_reg;
    logic [COL_W-1:0]    out_x_reg;
    logic [ROW_W-1:0]    out_y_reg;
    logic                out_color_reg;
    logic                out_last_reg;

    // setup terms
    logic                in_col_ok;
    logic                cur_ok;
    logic                col_ok;
    logic [HEIGHT_W-1:0] height;
    logic [COL_W-1:0]    x_calc;
    logic                xin_calc;
    logic [ROW_W-1:0]    y_lim;
    logic [ROW_W:0]      cand;
    logic                last_ok;

    // row terms
    logic                row_emit;
    logic                row_bar;
    logic                row_last;
    logic                out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            graph_left_reg   <= '0;
            graph_top_reg    <= '0;
            graph_bottom_reg <= ROW_W'(63);
            max_value_reg    <= SAMPLE_W'(64);
            mask_left_reg    <= COL_W'(127);
            mask_right_reg   <= '0;
            mask_top_reg     <= ROW_W'(63);
            mask_bottom_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_GRAPH_LEFT:   graph_left_reg   <= cfg_data[COL_W-1:0];
                REG_GRAPH_TOP:    graph_top_reg    <= cfg_data[ROW_W-1:0];
                REG_GRAPH_BOTTOM: graph_bottom_reg <= cfg_data[ROW_W-1:0];
                REG_MAX_VALUE:    max_value_reg    <= cfg_data[SAMPLE_W-1:0];
                REG_MASK_LEFT:    mask_left_reg    <= cfg_data[COL_W-1:0];
                REG_MASK_RIGHT:   mask_right_reg   <= cfg_data[COL_W-1:0];
                REG_MASK_TOP:     mask_top_reg     <= cfg_data[ROW_W-1:0];
                REG_MASK_BOTTOM:  mask_bottom_reg  <= cfg_data[ROW_W-1:0];
                default:          graph_left_reg   <= graph_left_reg;
            endcase
        end
    end

    // column range checks
    assign in_col_ok = {1'b0, in_column} < NCOL;
    assign cur_ok    = {1'b0, cursor_reg} < NCOL;
    assign col_ok    = {1'b0, col_reg} < NCOL;

    // clean flag updates
    always_comb
    begin
        clean_next = clean_reg;
        if (cmd.load)
        begin
            case (op_t'(in_opcode))
                OP_INV_COL:
                begin
                    if (in_col_ok)
                    begin
                        clean_next[in_column[IDX_W-1:0]] = 1'b0;
                    end
                end
                OP_CURSOR:
                begin
                    if (cur_ok)
                    begin
                        clean_next[cursor_reg[IDX_W-1:0]] = 1'b0;
                    end
                    if (in_col_ok)
                    begin
                        clean_next[in_column[IDX_W-1:0]] = 1'b0;
                    end
                end
                OP_INV_ALL:
                begin
                    clean_next = '0;
                end
                default:
                begin
                    clean_next = clean_reg;
                end
            endcase
        end
        if (cmd.setup && col_ok)
        begin
            clean_next[col_reg[IDX_W-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clean_reg  <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            clean_reg <= clean_next;
            if (cmd.load && op_t'(in_opcode) == OP_CURSOR)
            begin
                cursor_reg <= in_column;
            end
        end
    end

    // latch the item on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            col_reg    <= in_column;
            sample_reg <= in_sample;
        end
    end

    // column setup: height, pixel x, and the last row that will be emitted
    assign height   = HEIGHT_W'(graph_bottom_reg) - HEIGHT_W'(graph_top_reg) + HEIGHT_W'(1);
    assign x_calc   = graph_left_reg + col_reg;
    assign xin_calc = (x_calc >= mask_left_reg) && (x_calc <= mask_right_reg);
    assign y_lim    = (graph_bottom_reg < ROW_MAX) ? graph_bottom_reg : ROW_MAX;

    always_comb
    begin
        if (xin_calc && graph_top_reg >= mask_top_reg && graph_top_reg <= mask_bottom_reg)
        begin
            cand = {1'b0, mask_bottom_reg} + (ROW_W + 1)'(1);
        end
        else
        begin
            cand = {1'b0, graph_top_reg};
        end
    end

    assign last_ok = cand <= {1'b0, y_lim};

    assign status.in_is_draw = op_t'(in_opcode) == OP_DRAW;
    assign status.go = col_ok && !clean_reg[col_reg[IDX_W-1:0]]
                       && (graph_top_reg <= graph_bottom_reg) && last_ok;

    // walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            prod_reg      <= PROD_W'(23'(sample_reg) * 23'(height));
            acc_reg       <= PROD_W'(max_value_reg);
            mode_pass_reg <= max_value_reg == SAMPLE_W'(height);
            mode_full_reg <= max_value_reg == '0;
            fg_reg        <= col_reg != cursor_reg;
            x_reg         <= x_calc;
            xin_reg       <= xin_calc;
            y_reg         <= graph_bottom_reg;
            r_reg         <= '0;
            last_y_reg    <= cand[ROW_W-1:0];
        end
        else if (cmd.step)
        begin
            acc_reg <= acc_reg + PROD_W'(max_value_reg);
            y_reg   <= y_reg - ROW_W'(1);
            r_reg   <= r_reg + ROW_W'(1);
        end
    end

    // current row: visibility and color
    assign row_emit = (y_reg <= ROW_MAX)
                      && !(xin_reg && y_reg >= mask_top_reg && y_reg <= mask_bottom_reg);
    // row r is in the bar when (r + 1) * max_value <= sample * height
    assign row_bar  = mode_pass_reg ? (SAMPLE_W'(r_reg) < sample_reg)
                    : mode_full_reg ? 1'b1
                    : (acc_reg <= prod_reg);
    assign row_last = y_reg == last_y_reg;
    assign out_free = !out_valid_reg || out_ready;

    assign status.row_emit  = row_emit;
    assign status.out_free  = out_free;
    assign status.final_row = y_reg == graph_top_reg;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step && row_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && row_emit)
        begin
            out_x_reg     <= x_reg;
            out_y_reg     <= y_reg;
            out_color_reg <= row_bar ? fg_reg : !fg_reg;
            out_last_reg  <= row_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_color = out_color_reg;
    assign out_last  = out_last_reg;

    // an emitted row never overwrites a pixel that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && row_emit |-> out_free)
        else $error("pixel overwritten in output register");

    // invalidate all leaves every column dirty
    a_inv_all: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && op_t'(in_opcode) == OP_INV_ALL |=> clean_reg == '0)
        else $error("invalidate all left a clean column");

    // a visible top row is always the final pixel of the column
    a_last_on_top: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && status.final_row && row_emit |-> row_last)
        else $error("final emitted row not flagged last");

endmodule

`default_nettype wire

// File: design/bar_graph_column_renderer.sv
// draw on a dirty column: the item is latched, a setup state prepares the walk,
//   then rows go bottom up, one per cycle unless an emitted row waits for output
// a draw holds the input while it walks its H rows (H = graph height, at most 64),
//   output stalls included; other opcodes and clean-column draws walk no rows
// reset: every column dirty, cursor at column zero, registers at their defaults
`default_nettype none

module bar_graph_column_renderer #(
    parameter int NUM_COLUMNS  = 128,
    parameter int DISPLAY_ROWS = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [bgcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bgcr_pkg::CFG_DATA_W-1:0] cfg_data,
    bgcr_in_if.sink                              in_ch,
    bgcr_out_if.source                           out_ch
);
    import bgcr_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    // sequencer
    bgcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign in_ch.ready = in_ready;

    // column state, scaling and pixel generation
    bgcr_dp #(
        .NUM_COLUMNS  (NUM_COLUMNS),
        .DISPLAY_ROWS (DISPLAY_ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_opcode (in_ch.opcode),
        .in_column (in_ch.column_index),
        .in_sample (in_ch.sample_value),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .out_x     (out_ch.pixel_x),
        .out_y     (out_ch.pixel_y),
        .out_color (out_ch.pixel_color),
        .out_last  (out_ch.last_pixel)
    );

endmodule

`default_nettype wire

// File: dv/tb_bar_graph_column_renderer.sv
`default_nettype none

module tb_bar_graph_column_renderer;
    import bgcr_pkg::*;

    localparam int NUM_COLUMNS   = 128;
    localparam int DISPLAY_ROWS  = 64;
    // a draw holds the block while it walks its H rows, H at most 64
    localparam int SETTLE_CYCLES = 90;
    localparam int QUIET_LIMIT   = 3000;

    typedef struct packed {
        op_t                 op;
        logic [COL_W-1:0]    col;
        logic [SAMPLE_W-1:0] sample;
    } gfx_cmd_t;

    typedef struct packed {
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        logic             color;
        logic             last;
    } pixel_wr_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bgcr_in_if  in_ch ();
    bgcr_out_if out_ch ();

    bar_graph_column_renderer #(
        .NUM_COLUMNS  (NUM_COLUMNS),
        .DISPLAY_ROWS (DISPLAY_ROWS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // shadow of the block's registers and column state
    logic [COL_W-1:0]    g_left;
    logic [ROW_W-1:0]    g_top;
    logic [ROW_W-1:0]    g_bottom;
    logic [SAMPLE_W-1:0] g_max;
    logic [COL_W-1:0]    m_left;
    logic [COL_W-1:0]    m_right;
    logic [ROW_W-1:0]    m_top;
    logic [ROW_W-1:0]    m_bottom;
    bit                  col_dirty [NUM_COLUMNS];
    logic [COL_W-1:0]    cur_col;

    gfx_cmd_t  pending_cmds [$];
    pixel_wr_t pixel_writes_due [$];

    int  cmds_queued = 0;
    int  cmds_taken = 0;
    int  pixels_seen = 0;
    int  draws_taken = 0;
    int  layouts_applied = 0;
    int  errors = 0;
    bit  in_xfer = 1'b0;
    logic [COL_W-1:0] last_drawn = '0;

    always #10 clk = ~clk;

    // idle values on every block input
    initial
    begin
        in_ch.valid        = 1'b0;
        in_ch.opcode       = OP_DRAW;
        in_ch.column_index = '0;
        in_ch.sample_value = '0;
        out_ch.ready       = 1'b0;
    end

    // expected pixel writes of one command, updating the shadow state
    task automatic render_column(input gfx_cmd_t c);
        int               h;
        int               p;
        int               r;
        int               y;
        int               first_new;
        logic [COL_W-1:0] x;
        bit               fg;
        pixel_wr_t        pw;
        first_new = pixel_writes_due.size();
        case (c.op)
            OP_INV_COL:
                if (c.col < NUM_COLUMNS) col_dirty[c.col] = 1'b1;
            OP_CURSOR:
            begin
                if (cur_col < NUM_COLUMNS) col_dirty[cur_col] = 1'b1;
                cur_col = c.col;
                if (c.col < NUM_COLUMNS) col_dirty[c.col] = 1'b1;
            end
            OP_INV_ALL:
                foreach (col_dirty[i]) col_dirty[i] = 1'b1;
            default:
            begin
                if (c.col < NUM_COLUMNS && col_dirty[c.col])
                begin
                    col_dirty[c.col] = 1'b0;
                    h = (g_top > g_bottom) ? 0 : int'(g_bottom) - int'(g_top) + 1;
                    if (int'(g_max) == h)
                        p = int'(c.sample);
                    else if (g_max == 0)
                        p = h;
                    else
                        p = (int'(c.sample) * h) / int'(g_max);
                    if (p > h)
                        p = h;
                    fg = (c.col == cur_col) ? 1'b0 : 1'b1;
                    x = g_left + c.col;
                    for (r = 0; r < h; r++)
                    begin
                        y = int'(g_bottom) - r;
                        // skip rows off the display and pixels under the exclusion box
                        if (y < DISPLAY_ROWS && !(x >= m_left && x <= m_right &&
                                                  y >= m_top && y <= m_bottom))
                        begin
                            pw.x     = x;
                            pw.y     = ROW_W'(y);
                            pw.color = (r < p) ? fg : ~fg;
                            pw.last  = 1'b0;
                            pixel_writes_due.push_back(pw);
                        end
                    end
                    if (pixel_writes_due.size() > first_new)
                        pixel_writes_due[pixel_writes_due.size() - 1].last = 1'b1;
                end
            end
        endcase
    endtask

    // monitor: predict on input transfers, check output transfers
    always @(posedge clk)
    begin : monitor
        gfx_cmd_t  cmd;
        pixel_wr_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            pixels_seen++;
            if (pixel_writes_due.size() == 0)
            begin
                $error("unexpected pixel write x=%0d y=%0d color=%0d last=%0d",
                       out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_color,
                       out_ch.last_pixel);
                errors++;
            end
            else
            begin
                want = pixel_writes_due.pop_front();
                if (out_ch.pixel_x !== want.x)
                begin
                    $error("pixel_x: expected %0d, got %0d", want.x, out_ch.pixel_x);
                    errors++;
                end
                if (out_ch.pixel_y !== want.y)
                begin
                    $error("pixel_y: expected %0d, got %0d", want.y, out_ch.pixel_y);
                    errors++;
                end
                if (out_ch.pixel_color !== want.color)
                begin
                    $error("pixel_color: expected %0d, got %0d", want.color,
                           out_ch.pixel_color);
                    errors++;
                end
                if (out_ch.last_pixel !== want.last)
                begin
                    $error("last_pixel: expected %0d, got %0d", want.last,
                           out_ch.last_pixel);
                    errors++;
                end
            end
        end
        in_xfer = rst_n && in_ch.valid && in_ch.ready;
        if (in_xfer)
        begin
            cmd.op     = op_t'(in_ch.opcode);
            cmd.col    = in_ch.column_index;
            cmd.sample = in_ch.sample_value;
            if (cmd.op == OP_DRAW)
                draws_taken++;
            render_column(cmd);
            cmds_taken++;
        end
    end

    // watchdog on stretches with no transfer at all
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("no transfer for %0d cycles", quiet);
                $display("status: fail");
                $finish;
            end
        end
    end

    // command driver: bursts of random length with random gaps
    always @(negedge clk)
    begin : driver
        gfx_cmd_t nxt;
        int       burst_left;
        int       gap_left;
        if (rst_n && (!in_ch.valid || in_xfer))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                nxt = pending_cmds.pop_front();
                in_ch.valid        <= 1'b1;
                in_ch.opcode       <= nxt.op;
                in_ch.column_index <= nxt.col;
                in_ch.sample_value <= nxt.sample;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // pixel receiver: always ready, a fixed repeating 8-bit pattern, or ready at random 3 in 4
    always @(negedge clk)
    begin : receiver
        int         stall_mode;
        int         stall_span;
        logic [7:0] stall_bits;
        bit   [2:0] tick;
        if (stall_span <= 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_bits = 8'($urandom()) | 8'h01;
            stall_span = $urandom_range(20, 120);
        end
        stall_span--;
        tick++;
        case (stall_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= stall_bits[tick];
            default: out_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic push_cmd(input op_t op, input int col, input int sample);
        gfx_cmd_t c;
        c.op     = op;
        c.col    = COL_W'(col);
        c.sample = SAMPLE_W'(sample);
        pending_cmds.push_back(c);
        cmds_queued++;
    endtask

    // samples mostly in the range from zero to just over the current full-scale value
    function automatic int pick_sample();
        int sel;
        int lim;
        sel = $urandom_range(0, 9);
        lim = (g_max == 0) ? 64 : int'(g_max) + int'(g_max) / 8 + 1;
        if (lim > 65535)
            lim = 65535;
        if (sel == 0)
            return 65535;
        if (sel == 1)
            return 0;
        if (sel < 4)
            return $urandom_range(0, 65535);
        return $urandom_range(0, lim);
    endfunction

    // invalidate-then-draw pairs are the most common choice, so draws often hit dirty columns
    task automatic queue_traffic(input int n);
        int k;
        int pick;
        int c;
        k = 0;
        while (k < n)
        begin
            pick = $urandom_range(0, 99);
            c    = $urandom_range(0, 127);
            if (pick < 35)
            begin
                push_cmd(OP_INV_COL, c, $urandom_range(0, 65535));
                push_cmd(OP_DRAW, c, pick_sample());
                last_drawn = COL_W'(c);
                k += 2;
            end
            else if (pick < 60)
            begin
                push_cmd(OP_DRAW, c, pick_sample());
                last_drawn = COL_W'(c);
                k++;
            end
            else if (pick < 70)
            begin
                push_cmd(OP_CURSOR, c, $urandom_range(0, 65535));
                push_cmd(OP_DRAW, c, pick_sample());
                last_drawn = COL_W'(c);
                k += 2;
            end
            else if (pick < 78)
            begin
                push_cmd(OP_DRAW, last_drawn, pick_sample());
                k++;
            end
            else if (pick < 92)
            begin
                push_cmd(OP_INV_COL, c, $urandom_range(0, 65535));
                k++;
            end
            else
            begin
                push_cmd(OP_INV_ALL, c, $urandom_range(0, 65535));
                k++;
            end
        end
    endtask

    // wait for every command and pixel write, then let a silent draw finish
    task automatic wait_idle();
        do
            @(negedge clk);
        while (cmds_taken != cmds_queued || pixel_writes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_GRAPH_LEFT:   g_left   = data[COL_W-1:0];
            REG_GRAPH_TOP:    g_top    = data[ROW_W-1:0];
            REG_GRAPH_BOTTOM: g_bottom = data[ROW_W-1:0];
            REG_MAX_VALUE:    g_max    = data;
            REG_MASK_LEFT:    m_left   = data[COL_W-1:0];
            REG_MASK_RIGHT:   m_right  = data[COL_W-1:0];
            REG_MASK_TOP:     m_top    = data[ROW_W-1:0];
            default:          m_bottom = data[ROW_W-1:0];
        endcase
    endtask

    task automatic apply_layout(input int left, input int top, input int bottom,
                                input int maxv, input int ml, input int mr,
                                input int mt, input int mb);
        wait_idle();
        write_reg(REG_GRAPH_LEFT,   CFG_DATA_W'(left));
        write_reg(REG_GRAPH_TOP,    CFG_DATA_W'(top));
        write_reg(REG_GRAPH_BOTTOM, CFG_DATA_W'(bottom));
        write_reg(REG_MAX_VALUE,    CFG_DATA_W'(maxv));
        write_reg(REG_MASK_LEFT,    CFG_DATA_W'(ml));
        write_reg(REG_MASK_RIGHT,   CFG_DATA_W'(mr));
        write_reg(REG_MASK_TOP,     CFG_DATA_W'(mt));
        write_reg(REG_MASK_BOTTOM,  CFG_DATA_W'(mb));
        @(negedge clk);
        cfg_write <= 1'b0;
        layouts_applied++;
    endtask

    task automatic random_layout();
        int top;
        int bottom;
        int h;
        int maxv;
        int sel;
        int ml;
        int mr;
        int mt;
        int mb;
        top    = $urandom_range(0, 63);
        bottom = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                             : $urandom_range(top, 63);
        h      = (top > bottom) ? 0 : bottom - top + 1;
        sel    = $urandom_range(0, 9);
        if (sel < 3)
            maxv = h;
        else if (sel < 6)
            maxv = $urandom_range(1, 255);
        else if (sel < 9)
            maxv = $urandom_range(1, 65535);
        else
            maxv = 0;
        if ($urandom_range(0, 2) == 0)
        begin
            ml = 127; mr = 0; mt = 63; mb = 0;
        end
        else
        begin
            ml = $urandom_range(0, 127);
            mr = $urandom_range(ml, 127);
            mt = $urandom_range(0, 63);
            mb = $urandom_range(mt, 63);
        end
        apply_layout($urandom_range(0, 127), top, bottom, maxv, ml, mr, mt, mb);
    endtask

    initial
    begin
        // shadow starts at the reset values
        g_left = 0; g_top = 0; g_bottom = 63; g_max = 64;
        m_left = 127; m_right = 0; m_top = 63; m_bottom = 0;
        foreach (col_dirty[i]) col_dirty[i] = 1'b1;
        cur_col = '0;

        rst_n = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed commands on the reset layout: full height, pass-through scale
        push_cmd(OP_DRAW, 0, 0);            // cursor column, empty bar
        push_cmd(OP_DRAW, 127, 65535);      // saturates at full height
        push_cmd(OP_DRAW, 1, 32);
        push_cmd(OP_DRAW, 1, 10);           // clean column, nothing drawn
        push_cmd(OP_INV_COL, 1, 16'h5555);
        push_cmd(OP_DRAW, 1, 64);
        push_cmd(OP_CURSOR, 5, 16'hAAAA);
        push_cmd(OP_DRAW, 5, 20);
        push_cmd(OP_CURSOR, 127, 0);        // old and new cursor become dirty
        push_cmd(OP_DRAW, 5, 63);
        push_cmd(OP_DRAW, 127, 1);
        push_cmd(OP_INV_ALL, 0, 65535);
        push_cmd(OP_DRAW, 0, 65535);
        push_cmd(OP_DRAW, 64, 16'h5555);
        push_cmd(OP_DRAW, 42, 16'hAAAA);
        push_cmd(OP_CURSOR, 0, 65535);
        push_cmd(OP_INV_COL, 127, 16'hAAAA);
        push_cmd(OP_INV_COL, 0, 16'h5555);
        queue_traffic(40);

        // partial exclusion box, scale equals height
        apply_layout(5, 10, 40, 31, 20, 60, 15, 30);
        queue_traffic(45);
        // wrap of the x coordinate, largest full scale
        apply_layout(127, 0, 63, 65535, 127, 0, 63, 0);
        queue_traffic(40);
        // inverted graph area: columns turn clean with no pixels
        apply_layout(0, 40, 20, 1, 127, 0, 63, 0);
        queue_traffic(10);
        // zero full scale, everything under the exclusion box
        apply_layout(64, 0, 63, 0, 0, 127, 0, 63);
        queue_traffic(10);
        // one-row graph on the bottom display row
        apply_layout(3, 63, 63, 1, 127, 0, 63, 0);
        queue_traffic(20);
        // one-row graph on the top display row
        apply_layout(100, 0, 0, 65535, 127, 0, 63, 0);
        queue_traffic(15);
        // upper rows masked, last write lands below the box
        apply_layout(0, 0, 63, 64, 0, 127, 0, 30);
        queue_traffic(40);

        repeat (5)
        begin
            random_layout();
            queue_traffic(45);
        end
        wait_idle();

        $display("covered %0d commands (%0d draws) over %0d register layouts",
                 cmds_taken, draws_taken, layouts_applied);
        $display("checked %0d pixel writes, %0d mismatches", pixels_seen, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
design/bgcr_pkg.sv
design/bgcr_in_if.sv
design/bgcr_out_if.sv
design/bgcr_ctrl.sv
design/bgcr_dp.sv
design/bar_graph_column_renderer.sv
dv/tb_bar_graph_column_renderer.sv
